### rtl/led_strip_sweep_pattern_core_defines.svh
// assertion macros for the sweep pattern core
`ifndef LED_STRIP_SWEEP_PATTERN_CORE_DEFINES_SVH
`define LED_STRIP_SWEEP_PATTERN_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define LSSP_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lssp: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define LSSP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lssp: next-cycle check failed");

`else

`define LSSP_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define LSSP_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

### rtl/lssp_pkg.sv
package lssp_pkg;

    // strip and level limits
    localparam int MAX_PIXELS = 64;
    localparam logic [7:0] FULL_LEVEL = 8'd255;
    localparam logic [7:0] RAMP_SPAN = FULL_LEVEL - 8'd1;

    // field widths
    localparam int LEN_W     = 7;
    localparam int FADE_W    = 6;
    localparam int SPEED_W   = 16;
    localparam int COOL_W    = 20;
    localparam int ELAPSED_W = 10;
    localparam int INDEX_W   = 6;
    localparam int LEVEL_W   = 8;
    localparam int POS_W     = 28;
    localparam int POS_FRAC  = 18;
    localparam int HEAD_W    = POS_W - POS_FRAC;
    localparam int CLOCK_W   = 21;
    localparam int STEP_W    = SPEED_W + ELAPSED_W;
    localparam int CMP_W     = 12;

    // ramp division by reciprocal: numerator below 2^14, reciprocal ceil(2^20 / fade)
    localparam int NUM_W      = 14;
    localparam int RECIP_SH   = 20;
    localparam int RECIP_W    = RECIP_SH + 1;
    localparam int DIV_CNT_W  = 5;
    localparam int PROD_W     = NUM_W + RECIP_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIP_LENGTH = 2'd0,
        CFG_FADE_SIZE    = 2'd1,
        CFG_SWEEP_SPEED  = 2'd2,
        CFG_COOL_DOWN    = 2'd3
    } t_cfg_idx;

    localparam logic [LEN_W-1:0]   RST_STRIP_LENGTH = 7'd64;
    localparam logic [FADE_W-1:0]  RST_FADE_SIZE    = 6'd8;
    localparam logic [SPEED_W-1:0] RST_SWEEP_SPEED  = 16'd2560;
    localparam logic [COOL_W-1:0]  RST_COOL_DOWN    = 20'd2048;

    typedef struct packed {
        logic [LEN_W-1:0]   strip_length;
        logic [FADE_W-1:0]  fade_size;
        logic [SPEED_W-1:0] sweep_speed;
        logic [COOL_W-1:0]  cool_down;
    } t_cfg;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_DIV,
        S_LOAD,
        S_PIXELS,
        S_UPDATE
    } t_state;

    // pixel region select
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_FULL,
        SEL_DOWN,
        SEL_UP
    } t_sel;

    typedef struct packed {
        logic take;
        logic wait_upd;
        logic div_step;
        logic load;
        logic issue;
        logic pos_upd;
    } t_cmd;

    typedef struct packed {
        logic is_wait;
        logic div_last;
        logic stage_busy;
        logic can_issue;
        logic pix_last;
        logic len_zero;
    } t_status;

endpackage

### rtl/lssp_tick_if.sv
interface lssp_tick_if
    import lssp_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ELAPSED_W-1:0] elapsed_time;

    modport source (output valid, output elapsed_time, input ready);
    modport sink (input valid, input elapsed_time, output ready);
endinterface

### rtl/lssp_pixel_if.sv
interface lssp_pixel_if
    import lssp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] pixel_index;
    logic [LEVEL_W-1:0] pixel_level;
    logic               last_pixel;

    modport source (output valid, output pixel_index, output pixel_level,
                    output last_pixel, input ready);
    modport sink (input valid, input pixel_index, input pixel_level,
                  input last_pixel, output ready);
endinterface

### rtl/lssp_cfg_if.sv
interface lssp_cfg_if
    import lssp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/lssp_cfg_regs.sv
module lssp_cfg_regs
    import lssp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // writes are never stalled, held off during reset
    assign o_cfg_ready = i_rst_n;
    assign o_cfg = r_cfg;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strip_length <= RST_STRIP_LENGTH;
            r_cfg.fade_size    <= RST_FADE_SIZE;
            r_cfg.sweep_speed  <= RST_SWEEP_SPEED;
            r_cfg.cool_down    <= RST_COOL_DOWN;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STRIP_LENGTH: r_cfg.strip_length <= i_cfg_data[LEN_W-1:0];
                CFG_FADE_SIZE:    r_cfg.fade_size    <= i_cfg_data[FADE_W-1:0];
                CFG_SWEEP_SPEED:  r_cfg.sweep_speed  <= i_cfg_data[SPEED_W-1:0];
                CFG_COOL_DOWN:    r_cfg.cool_down    <= i_cfg_data[COOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/lssp_ctrl.sv
module lssp_ctrl
    import lssp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tick_valid,
    output logic    o_tick_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_tick_valid) begin
                    n_state = i_status.is_wait ? S_WAIT : S_DIV;
                end
            end
            S_WAIT: begin
                n_state = S_IDLE;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!i_status.stage_busy) begin
                    n_state = i_status.len_zero ? S_UPDATE : S_PIXELS;
                end
            end
            S_PIXELS: begin
                if (i_status.can_issue && i_status.pix_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs, no tick taken while reset is held
    always_comb begin
        o_cmd = '0;
        o_tick_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_tick_ready = i_rst_n;
                o_cmd.take = i_tick_valid && i_rst_n;
            end
            S_WAIT: begin
                o_cmd.wait_upd = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_LOAD: begin
                o_cmd.load = !i_status.stage_busy;
            end
            S_PIXELS: begin
                o_cmd.issue = i_status.can_issue;
            end
            S_UPDATE: begin
                o_cmd.pos_upd = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/lssp_datapath.sv
`include "led_strip_sweep_pattern_core_defines.svh"

module lssp_datapath
    import lssp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic [ELAPSED_W-1:0] i_elapsed_time,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [INDEX_W-1:0]   o_pixel_index,
    output logic [LEVEL_W-1:0]   o_pixel_level,
    output logic                 o_last_pixel
);

    // tick state
    logic                 r_phase;
    logic [POS_W-1:0]     r_position;
    logic [CLOCK_W-1:0]   r_wait_clock;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [STEP_W-1:0]    r_step;

    // reciprocal divider
    logic [FADE_W-1:0]    r_div_rem;
    logic [RECIP_SH-1:0]  r_div_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [RECIP_W-1:0]   r_recip;

    // pixel pipeline
    logic [INDEX_W-1:0] r_pix;
    logic               r_a_valid;
    t_sel               r_a_sel;
    logic [INDEX_W-1:0] r_a_index;
    logic               r_a_last;
    logic [NUM_W-1:0]   r_a_num;
    logic               r_b_valid;
    t_sel               r_b_sel;
    logic [INDEX_W-1:0] r_b_index;
    logic               r_b_last;
    logic [LEVEL_W-1:0] r_b_quo;
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;
    logic [LEVEL_W-1:0] r_out_level;
    logic               r_out_last;

    logic [LEN_W-1:0]     eff_len;
    logic [INDEX_W-1:0]   last_index;
    logic                 pipe_en;
    logic                 pix_last;
    logic [FADE_W:0]      div_shift;
    logic                 div_ge;
    logic [FADE_W-1:0]    div_rem_nx;
    logic [CLOCK_W-1:0]   wait_sum;
    logic [POS_W-1:0]     pos_sum;
    logic [POS_W-1:0]     pos_limit;
    logic signed [CMP_W-1:0] pix_s;
    logic signed [CMP_W-1:0] head_s;
    logic signed [CMP_W-1:0] body_s;
    logic signed [CMP_W-1:0] tail_s;
    logic signed [CMP_W-1:0] black_s;
    logic signed [CMP_W-1:0] off_s;
    t_sel                 sel;
    logic [NUM_W-1:0]     num;
    logic [PROD_W-1:0]    prod;
    logic [LEVEL_W-1:0]   level;

    // effective strip length, saturated
    assign eff_len = (i_cfg.strip_length > LEN_W'(MAX_PIXELS))
                   ? LEN_W'(MAX_PIXELS) : i_cfg.strip_length;
    assign last_index = INDEX_W'(eff_len - LEN_W'(1));

    assign pipe_en  = !r_out_valid || i_out_ready;
    assign pix_last = (LEN_W'(r_pix) + LEN_W'(1)) == eff_len;

    assign o_status.is_wait    = r_phase;
    assign o_status.div_last   = r_div_cnt == DIV_CNT_W'(RECIP_SH - 1);
    assign o_status.stage_busy = r_a_valid;
    assign o_status.can_issue  = pipe_en;
    assign o_status.pix_last   = pix_last;
    assign o_status.len_zero   = eff_len == '0;

    // restoring division of all-ones by fade size, one quotient bit a cycle
    assign div_shift  = {r_div_rem, 1'b1};
    assign div_ge     = div_shift >= {1'b0, i_cfg.fade_size};
    assign div_rem_nx = div_ge ? FADE_W'(div_shift - {1'b0, i_cfg.fade_size})
                               : FADE_W'(div_shift);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_elapsed <= i_elapsed_time;
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_rem <= div_rem_nx;
            r_div_quo <= {r_div_quo[RECIP_SH-2:0], div_ge};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.load) begin
            r_recip <= RECIP_W'(r_div_quo) + RECIP_W'(1);
            r_step  <= STEP_W'(i_cfg.sweep_speed) * STEP_W'(r_elapsed);
        end
    end

    // position and wait clock
    assign wait_sum  = r_wait_clock + CLOCK_W'(r_elapsed);
    assign pos_sum   = r_position + POS_W'(r_step);
    assign pos_limit = POS_W'({eff_len, 1'b0}) << POS_FRAC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= 1'b0;
            r_position   <= '0;
            r_wait_clock <= '0;
        end else if (i_cmd.wait_upd) begin
            r_wait_clock <= wait_sum;
            if (wait_sum >= CLOCK_W'(i_cfg.cool_down)) begin
                r_phase <= 1'b0;
            end
        end else if (i_cmd.pos_upd) begin
            if (pos_sum >= pos_limit) begin
                r_position   <= '0;
                r_wait_clock <= '0;
                r_phase      <= 1'b1;
            end else begin
                r_position <= pos_sum;
            end
        end
    end

    // pixel region from signed band edges
    assign pix_s   = $signed(CMP_W'(r_pix));
    assign head_s  = $signed(CMP_W'(r_position[POS_W-1:POS_FRAC]));
    assign body_s  = head_s - $signed(CMP_W'(i_cfg.fade_size));
    assign black_s = head_s - $signed(CMP_W'(eff_len));
    assign tail_s  = black_s + $signed(CMP_W'(i_cfg.fade_size));

    always_comb begin
        sel   = SEL_ZERO;
        off_s = '0;
        if (pix_s > head_s) begin
            sel = SEL_ZERO;
        end else if (pix_s > body_s) begin
            sel   = SEL_DOWN;
            off_s = pix_s - body_s;
        end else if (pix_s > tail_s) begin
            sel = SEL_FULL;
        end else if (pix_s > black_s) begin
            sel   = SEL_UP;
            off_s = pix_s - black_s;
        end
    end

    // ramp numerator: offset times span
    assign num = NUM_W'(off_s[FADE_W-1:0]) * NUM_W'(RAMP_SPAN);

    // stage a: pixel counter and region
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix <= '0;
        end else if (i_cmd.issue) begin
            r_pix <= r_pix + INDEX_W'(1);
        end
        if (pipe_en && i_cmd.issue) begin
            r_a_sel   <= sel;
            r_a_index <= r_pix;
            r_a_last  <= pix_last;
            r_a_num   <= num;
        end
    end

    // stage b: quotient by reciprocal
    assign prod = PROD_W'(r_a_num) * PROD_W'(r_recip);

    always_ff @(posedge i_clk) begin
        if (pipe_en && r_a_valid) begin
            r_b_sel   <= r_a_sel;
            r_b_index <= r_a_index;
            r_b_last  <= r_a_last;
            r_b_quo   <= prod[RECIP_SH+LEVEL_W-1:RECIP_SH];
        end
    end

    // output level
    always_comb begin
        case (r_b_sel)
            SEL_FULL: level = FULL_LEVEL;
            SEL_DOWN: level = FULL_LEVEL - r_b_quo;
            SEL_UP:   level = r_b_quo + LEVEL_W'(1);
            default:  level = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en && r_b_valid) begin
            r_out_index <= r_b_index;
            r_out_level <= level;
            r_out_last  <= r_b_last;
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_a_valid   <= i_cmd.issue;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_b_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_out_index;
    assign o_pixel_level = r_out_level;
    assign o_last_pixel  = r_out_last;

    // checks
    `LSSP_ASSERT_IMPLY(a_wait_pos_clear, i_clk, i_rst_n, r_phase, r_position == '0)
    `LSSP_ASSERT_IMPLY(a_load_stage_empty, i_clk, i_rst_n, i_cmd.load, !r_a_valid)
    `LSSP_ASSERT_IMPLY(a_issue_moves, i_clk, i_rst_n, i_cmd.issue, pipe_en)
    `LSSP_ASSERT_IMPLY(a_last_index, i_clk, i_rst_n, r_out_valid && r_out_last,
        r_out_index == last_index)

endmodule

### rtl/led_strip_sweep_pattern_core.sv
// led strip sweep pattern core
// i_tick carries one word per time tick: elapsed_time since the previous tick in
// 1/1024 s. o_pixel returns one word per strip pixel (pixel_index, pixel_level,
// last_pixel) while the band sweeps, and nothing while it waits out the cool-down.
// i_cfg writes strip_length (0), fade_size (1), sweep_speed (2), cool_down (3);
// write only while the core is idle and all pixel words are taken.
// a sweep tick first runs a 20-step reciprocal divider on fade_size, then issues
// one pixel per cycle through a three-register pipeline while the receiver does
// not stall. a wait tick only advances the wait clock and may end the cool-down.
// i_tick.ready is high only between ticks.
// a stalled receiver holds the output register and freezes the pixel pipeline;
// no word is dropped. the next tick may be taken while pixels of the previous
// one are still waiting to go out.
// synchronous reset restores the register defaults, clears the band position
// and wait clock and starts in the sweep phase.
module led_strip_sweep_pattern_core
    import lssp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    lssp_tick_if.sink    i_tick,
    lssp_pixel_if.source o_pixel,
    lssp_cfg_if.sink     i_cfg
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    lssp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_cfg_ready (i_cfg.ready),
        .o_cfg       (cfg)
    );

    lssp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (i_tick.valid),
        .o_tick_ready (i_tick.ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    lssp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_elapsed_time (i_tick.elapsed_time),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (o_pixel.ready),
        .o_out_valid    (o_pixel.valid),
        .o_pixel_index  (o_pixel.pixel_index),
        .o_pixel_level  (o_pixel.pixel_level),
        .o_last_pixel   (o_pixel.last_pixel)
    );

endmodule

### sim/sweep_frame_checker.sv
`timescale 1ns / 100ps

module sweep_frame_checker
    import lssp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    lssp_tick_if  tick_mon,
    lssp_pixel_if pixel_mon,
    lssp_cfg_if   cfg_mon,
    output int    o_errors,
    output int    o_pending,
    output int    o_words,
    output int    o_sweeps
);

    localparam int FULL = int'(FULL_LEVEL);

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } t_pixel_word;

    // shadow copy of the registers
    logic [LEN_W-1:0]   strip_length;
    logic [FADE_W-1:0]  fade_size;
    logic [SPEED_W-1:0] sweep_speed;
    logic [COOL_W-1:0]  cool_down;

    // band state
    logic [POS_W-1:0]   band_pos;
    logic [CLOCK_W-1:0] wait_clock;
    logic               cooling;

    t_pixel_word due_pixels[$];
    int error_count = 0;
    int word_count  = 0;
    int sweep_count = 0;

    // brightness of one pixel for a band whose head sits at pixel head
    function automatic logic [LEVEL_W-1:0] band_level(input int px, input int head,
                                                      input int fade, input int len);
        int body;
        int tail;
        int black;
        int lv;
        body  = head - fade;
        tail  = body - (len - 2 * fade);
        black = tail - fade;
        if (px > head) begin
            lv = 0;
        end else if (px > body) begin
            lv = (fade == 0) ? 0 : FULL + ((px - body) * (1 - FULL)) / fade;
        end else if (px > tail) begin
            lv = FULL;
        end else if (px > black) begin
            lv = (fade == 0) ? 0 : 1 + ((px - black) * (FULL - 1)) / fade;
        end else begin
            lv = 0;
        end
        return lv[LEVEL_W-1:0];
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        error_count++;
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    endtask

    // frame for one tick, then move the band or run the cool-down clock
    task automatic take_tick(input logic [ELAPSED_W-1:0] elapsed);
        int len;
        int head;
        int px;
        t_pixel_word w;
        if (cooling) begin
            wait_clock = wait_clock + elapsed;
            if (wait_clock >= cool_down) begin
                cooling = 1'b0;
            end
            return;
        end
        len  = (strip_length > MAX_PIXELS) ? MAX_PIXELS : int'(strip_length);
        head = int'(band_pos[POS_W-1:POS_FRAC]);
        for (px = 0; px < len; px++) begin
            w.index = px[INDEX_W-1:0];
            w.level = band_level(px, head, int'(fade_size), len);
            w.last  = (px == len - 1);
            due_pixels.push_back(w);
        end
        band_pos = band_pos + sweep_speed * elapsed;
        // band fully gone: start the cool-down
        if (int'(band_pos) >= ((2 * len) << POS_FRAC)) begin
            band_pos   = '0;
            wait_clock = '0;
            cooling    = 1'b1;
            sweep_count++;
        end
    endtask

    // compare one pixel word with the oldest one due
    task automatic check_word();
        t_pixel_word want;
        word_count++;
        if (due_pixels.size() == 0) begin
            error_count++;
            $error("pixel word with nothing due: index %0d level %0d last %0d",
                   pixel_mon.pixel_index, pixel_mon.pixel_level, pixel_mon.last_pixel);
            return;
        end
        want = due_pixels.pop_front();
        if (pixel_mon.pixel_index !== want.index) begin
            report_field("pixel_index", want.index, pixel_mon.pixel_index);
        end
        if (pixel_mon.pixel_level !== want.level) begin
            report_field("pixel_level", want.level, pixel_mon.pixel_level);
        end
        if (pixel_mon.last_pixel !== want.last) begin
            report_field("last_pixel", want.last, pixel_mon.last_pixel);
        end
    endtask

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            strip_length = RST_STRIP_LENGTH;
            fade_size    = RST_FADE_SIZE;
            sweep_speed  = RST_SWEEP_SPEED;
            cool_down    = RST_COOL_DOWN;
            band_pos     = '0;
            wait_clock   = '0;
            cooling      = 1'b0;
            due_pixels.delete();
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (t_cfg_idx'(cfg_mon.index))
                    CFG_STRIP_LENGTH: strip_length = cfg_mon.data[LEN_W-1:0];
                    CFG_FADE_SIZE:    fade_size    = cfg_mon.data[FADE_W-1:0];
                    CFG_SWEEP_SPEED:  sweep_speed  = cfg_mon.data[SPEED_W-1:0];
                    CFG_COOL_DOWN:    cool_down    = cfg_mon.data[COOL_W-1:0];
                    default: ;
                endcase
            end
            if (pixel_mon.valid && pixel_mon.ready) begin
                check_word();
            end
            if (tick_mon.valid && tick_mon.ready) begin
                take_tick(tick_mon.elapsed_time);
            end
        end
        o_errors  <= error_count;
        o_pending <= due_pixels.size();
        o_words   <= word_count;
        o_sweeps  <= sweep_count;
    end

endmodule

### sim/tb_led_strip_sweep_pattern_core.sv
`timescale 1ns / 100ps

module tb_led_strip_sweep_pattern_core;
    import lssp_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int TOTAL_TICKS   = 380;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int HOLD_AFTER    = 60;
    localparam int HOLD_CYCLES   = 500;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int ticks_sent  = 0;
    int cfg_changes = 0;
    int fail_count;
    int pending;
    int words;
    int sweeps;

    lssp_tick_if  tick_bus ();
    lssp_pixel_if pixel_bus ();
    lssp_cfg_if   cfg_bus ();

    led_strip_sweep_pattern_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_bus),
        .o_pixel (pixel_bus),
        .i_cfg   (cfg_bus)
    );

    sweep_frame_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .tick_mon  (tick_bus),
        .pixel_mon (pixel_bus),
        .cfg_mon   (cfg_bus),
        .o_errors  (fail_count),
        .o_pending (pending),
        .o_words   (words),
        .o_sweeps  (sweeps)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // offer one tick word, wait until taken, then maybe leave a gap
    task automatic send_tick(input logic [ELAPSED_W-1:0] elapsed);
        int gap;
        int roll;
        tick_bus.valid        <= 1'b1;
        tick_bus.elapsed_time <= elapsed;
        @(posedge i_clk);
        while (!tick_bus.ready) @(posedge i_clk);
        ticks_sent++;
        roll = $urandom_range(0, 99);
        gap  = (roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap > 0) begin
            tick_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
    endtask

    // write all four registers back to back
    task automatic load_settings(input t_cfg s);
        write_reg(CFG_STRIP_LENGTH, CFG_DATA_W'(s.strip_length));
        write_reg(CFG_FADE_SIZE, CFG_DATA_W'(s.fade_size));
        write_reg(CFG_SWEEP_SPEED, CFG_DATA_W'(s.sweep_speed));
        write_reg(CFG_COOL_DOWN, CFG_DATA_W'(s.cool_down));
        cfg_bus.valid <= 1'b0;
        cfg_changes++;
    endtask

    // stop offering, drain all due pixels, then let a tick with no pixels finish
    task automatic wait_idle();
        int guard;
        guard = 0;
        tick_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // pixel receiver: random stalls, quiet stretches and one long hold-off
    // taken while pixels flow and the sender is offering the next tick
    initial begin : pixel_sink
        int  stall_left;
        int  quiet_left;
        int  roll;
        bit  held;
        stall_left = 0;
        quiet_left = 0;
        held       = 1'b0;
        pixel_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                pixel_bus.ready <= 1'b0;
            end else if (!held && ticks_sent >= HOLD_AFTER && pixel_bus.valid &&
                         tick_bus.valid) begin
                held = 1'b1;
                pixel_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_left > 0) begin
                pixel_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                pixel_bus.ready <= 1'b1;
                if (quiet_left > 0) begin
                    quiet_left--;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 2) begin
                        quiet_left = $urandom_range(50, 200);
                    end else if (roll < 16) begin
                        stall_left = $urandom_range(1, 3);
                    end else if (roll < 19) begin
                        stall_left = $urandom_range(10, 60);
                    end
                end
            end
        end
    end

    // main stimulus and verdict
    initial begin : stimulus
        t_cfg pick;
        int   n;
        int   i;
        int   roll;
        tick_bus.valid        = 1'b0;
        tick_bus.elapsed_time = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = CFG_STRIP_LENGTH;
        cfg_bus.data          = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults, elapsed extremes and alternating bits
        send_tick(10'd0);
        send_tick(10'd1023);
        send_tick(10'h155);
        send_tick(10'h2AA);

        // empty strip: no pixels, straight into a zero cool-down
        wait_idle();
        load_settings(t_cfg'{strip_length: 7'd0, fade_size: 6'd8,
                             sweep_speed: 16'd2560, cool_down: 20'd0});
        repeat (3) send_tick(10'd5);

        // strip longer than the maximum, no ramps, full speed
        wait_idle();
        load_settings(t_cfg'{strip_length: 7'd127, fade_size: 6'd0,
                             sweep_speed: 16'hFFFF, cool_down: 20'd0});
        repeat (3) send_tick(10'd1023);
        send_tick(10'd1);

        // ramps wider than half the strip, negative body
        wait_idle();
        load_settings(t_cfg'{strip_length: 7'd5, fade_size: 6'd32,
                             sweep_speed: 16'd8192, cool_down: 20'd3});
        repeat (8) send_tick(10'd64);

        // single pixel, widest fade, band standing still
        wait_idle();
        load_settings(t_cfg'{strip_length: 7'd1, fade_size: 6'd63,
                             sweep_speed: 16'd0, cool_down: 20'd0});
        repeat (2) send_tick(10'd1023);

        // one-pixel ramps, longest cool-down: stays in the wait phase
        wait_idle();
        load_settings(t_cfg'{strip_length: 7'd64, fade_size: 6'd1,
                             sweep_speed: 16'hFFFF, cool_down: 20'hFFFFF});
        repeat (3) send_tick(10'd1023);

        // random settings, mostly sane with a share of odd corners
        while (ticks_sent < TOTAL_TICKS) begin
            wait_idle();
            roll = $urandom_range(0, 99);
            pick.strip_length = (roll < 5)  ? LEN_W'(0) :
                                (roll < 15) ? LEN_W'($urandom_range(65, 127)) :
                                              LEN_W'($urandom_range(1, 64));
            roll = $urandom_range(0, 99);
            pick.fade_size = (roll < 10) ? FADE_W'(0) :
                             (roll < 25) ? FADE_W'($urandom_range(33, 63)) :
                                           FADE_W'($urandom_range(1, 32));
            roll = $urandom_range(0, 99);
            pick.sweep_speed = (roll < 10) ? SPEED_W'($urandom_range(0, 299)) :
                               (roll < 20) ? SPEED_W'($urandom_range(6000, 65535)) :
                                             SPEED_W'($urandom_range(300, 6000));
            roll = $urandom_range(0, 99);
            pick.cool_down = (roll < 20) ? COOL_W'(0) :
                             (roll < 95) ? COOL_W'($urandom_range(1, 2500)) :
                                           COOL_W'($urandom_range(2500, 1048575));
            load_settings(pick);
            n = $urandom_range(20, 45);
            for (i = 0; i < n && ticks_sent < TOTAL_TICKS; i++) begin
                send_tick(($urandom_range(0, 99) < 60) ? ELAPSED_W'($urandom_range(0, 255)) :
                                                         ELAPSED_W'($urandom_range(0, 1023)));
            end
        end

        wait_idle();
        $display("ran %0d tick words under %0d register settings, %0d pixel words checked",
                 ticks_sent, cfg_changes, words);
        $display("%0d sweeps crossed the strip and entered the cool-down wait", sweeps);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // run time guard
    initial begin : watchdog
        #60000000;
        $display("timeout: run did not finish, %0d pixel words still due", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/lssp_pkg.sv
rtl/lssp_tick_if.sv
rtl/lssp_pixel_if.sv
rtl/lssp_cfg_if.sv
rtl/lssp_cfg_regs.sv
rtl/lssp_ctrl.sv
rtl/lssp_datapath.sv
rtl/led_strip_sweep_pattern_core.sv
sim/sweep_frame_checker.sv
sim/tb_led_strip_sweep_pattern_core.sv
